// ----- sv/swrp_pkg.sv -----
// ----------------------------------------------------------------------------
// swrp_pkg
// Shared types and constants of the sliding-window rate policer.
// ----------------------------------------------------------------------------
package swrp_pkg;

   localparam int DEF_NUM_FLOWS    = 64;
   localparam int DEF_WINDOW_DEPTH = 16;

   localparam int IDX_W  = 12;   // holds a flow index for up to 4096 flows
   localparam int LIM_W  = 26;   // window_ms * 1000 fits in 26 bits
   localparam int PROD_W = 49;   // 32 x 17 product
   localparam int SUM_W  = 40;

   localparam logic       OP_QUERY  = 1'b0;
   localparam logic       OP_UPDATE = 1'b1;

   // x / 8000000 = ((x >> 9) * RCP_FRAME) >> 54, exact for x < 2^49
   // x / 1000    = ((x >> 3) * RCP_MS) >> 52,    exact for x < 2^48
   localparam int                PRE_FRAME = 9;
   localparam int                PRE_MS    = 3;
   localparam int                SH_FRAME  = 54;
   localparam int                SH_MS     = 52;
   localparam logic [PROD_W-1:0] RCP_FRAME = 49'd1152921504607;
   localparam logic [PROD_W-1:0] RCP_MS    = 49'd36028797018964;

   localparam logic [PROD_W-1:0] CEIL_BIAS  = 49'd7999999;
   localparam logic [16:0]       FRAME_RST  = 17'd5000;
   localparam logic [9:0]        US_PER_MS  = 10'd1000;

   typedef struct packed {
      logic             is_update;
      logic [IDX_W-1:0] flow_idx;
      logic [31:0]      now_us;
      logic [31:0]      sustained_rate;
      logic [31:0]      reserved_rate;
      logic [31:0]      max_burst;
      logic [15:0]      window_ms;
      logic [LIM_W-1:0] limit_us;
      logic [31:0]      queue_bytes;
      logic [31:0]      granted_sustained;
      logic [31:0]      granted_reserved;
   } item_type;

endpackage

// ----- sv/sliding_window_rate_policer_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rate_policer_unit
// Per-flow sliding-window policer: queries allowed sizes, records grants.
// ----------------------------------------------------------------------------
//  channel | ports                     | direction | handshake
//  req     | req_opcode .. granted_*   | in        | req_valid / req_stall
//  rsp     | rsp_allowed_*, flow_known | out       | rsp_valid / rsp_stall
//  csr     | csr_wr_data (frame us)    | in        | csr_wr_en, no wait
//
//  Query: lookup, product, the four-step reciprocal multiply of the divider, cap.
//  Update of a known flow: lookup, evict the oldest entry if full (ring read),
//  append, then age out expired head entries; first update: lookup, then emit.
//  After reset, a clearing pass walks all NUM_FLOWS flow table entries;
//  up to two items are queued meanwhile.
//  A stalled result holds its register; the two-entry queue keeps taking items until full.
// ----------------------------------------------------------------------------
module sliding_window_rate_policer_unit import swrp_pkg::*; #(
   parameter int NUM_FLOWS    = DEF_NUM_FLOWS,
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_flow_id,
   input  logic [31:0] req_now_us,
   input  logic [31:0] req_sustained_rate,
   input  logic [31:0] req_reserved_rate,
   input  logic [31:0] req_max_burst,
   input  logic [15:0] req_window_ms,
   input  logic [31:0] req_queue_bytes,
   input  logic [31:0] req_granted_sustained,
   input  logic [31:0] req_granted_reserved,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_allowed_sustained,
   output logic [31:0] rsp_allowed_reserved,
   output logic        rsp_flow_known,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   logic [16:0] frame_ff, frame_in;
   item_type    front_item, q_item;
   logic        q_push, q_pop, q_empty, q_full;

   always_comb begin
      frame_in = csr_wr_en ? csr_wr_data : frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_RST;
      end else begin
         frame_ff <= frame_in;
      end
   end

   swrp_front #(.NUM_FLOWS(NUM_FLOWS)) u_front (
      .req_opcode            (req_opcode),
      .req_flow_id           (req_flow_id),
      .req_now_us            (req_now_us),
      .req_sustained_rate    (req_sustained_rate),
      .req_reserved_rate     (req_reserved_rate),
      .req_max_burst         (req_max_burst),
      .req_window_ms         (req_window_ms),
      .req_queue_bytes       (req_queue_bytes),
      .req_granted_sustained (req_granted_sustained),
      .req_granted_reserved  (req_granted_reserved),
      .item                  (front_item)
   );

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   swrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (q_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   swrp_back #(.NUM_FLOWS(NUM_FLOWS), .WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .frame_us              (frame_ff),
      .q_item                (q_item),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_allowed_sustained (rsp_allowed_sustained),
      .rsp_allowed_reserved  (rsp_allowed_reserved),
      .rsp_flow_known        (rsp_flow_known)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back popped an empty queue");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |=> req_stall)
      else $error("queue full without pop but input not stalled");

endmodule

// ----- sv/swrp_front.sv -----
// ----------------------------------------------------------------------------
// swrp_front
// Classifies an incoming item: opcode decode, flow index wrap, window limit.
// ----------------------------------------------------------------------------
module swrp_front import swrp_pkg::*; #(
   parameter int NUM_FLOWS = DEF_NUM_FLOWS
) (
   input  logic        req_opcode,
   input  logic [5:0]  req_flow_id,
   input  logic [31:0] req_now_us,
   input  logic [31:0] req_sustained_rate,
   input  logic [31:0] req_reserved_rate,
   input  logic [31:0] req_max_burst,
   input  logic [15:0] req_window_ms,
   input  logic [31:0] req_queue_bytes,
   input  logic [31:0] req_granted_sustained,
   input  logic [31:0] req_granted_reserved,
   output item_type    item
);

   logic [IDX_W-1:0] idx;

   always_comb begin
      idx = '0;
      for (int k = 0; k < 64; k++) begin
         if (req_flow_id == 6'(k)) begin
            idx = IDX_W'(k % NUM_FLOWS);
         end
      end
   end

   always_comb begin
      item.is_update         = (req_opcode == OP_UPDATE);
      item.flow_idx          = idx;
      item.now_us            = req_now_us;
      item.sustained_rate    = req_sustained_rate;
      item.reserved_rate     = req_reserved_rate;
      item.max_burst         = req_max_burst;
      item.window_ms         = req_window_ms;
      item.limit_us          = LIM_W'({10'd0, req_window_ms} * {16'd0, US_PER_MS});
      item.queue_bytes       = req_queue_bytes;
      item.granted_sustained = req_granted_sustained;
      item.granted_reserved  = req_granted_reserved;
   end

endmodule

// ----- sv/swrp_queue.sv -----
// ----------------------------------------------------------------------------
// swrp_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module swrp_queue import swrp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     empty,
   output logic     full
);

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rptr_ff];
   assign empty     = (cnt_ff == 2'd0);
   assign full      = (cnt_ff == 2'd2);

endmodule

// ----- sv/swrp_cdiv.sv -----
// ----------------------------------------------------------------------------
// swrp_cdiv
// Divider by 8000000 or by 1000 through a reciprocal multiply, built from
// four 32 x 32 partial products accumulated in turn.
// ----------------------------------------------------------------------------
module swrp_cdiv import swrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              use_frame,
   input  logic [PROD_W-1:0] dividend,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   localparam int ACC_W = 2 * PROD_W;

   logic [PROD_W-1:0] y_ff, y_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              frame_ff, frame_in;
   logic [PROD_W-1:0] rcp;
   logic [31:0]       opa, opb;
   logic [63:0]       pp;
   logic [ACC_W-1:0]  pp_sh;

   always_comb begin
      rcp   = frame_ff ? RCP_FRAME : RCP_MS;
      opa   = '0;
      opb   = '0;
      pp_sh = '0;
      unique case (step_ff)
         2'd0: begin
            opa = y_ff[31:0];
            opb = rcp[31:0];
         end
         2'd1: begin
            opa = y_ff[31:0];
            opb = 32'(rcp[PROD_W-1:32]);
         end
         2'd2: begin
            opa = 32'(y_ff[PROD_W-1:32]);
            opb = rcp[31:0];
         end
         2'd3: begin
            opa = 32'(y_ff[PROD_W-1:32]);
            opb = 32'(rcp[PROD_W-1:32]);
         end
      endcase
      pp = {32'd0, opa} * {32'd0, opb};
      unique case (step_ff)
         2'd0:       pp_sh = ACC_W'(pp);
         2'd1, 2'd2: pp_sh = ACC_W'(pp) << 32;
         2'd3:       pp_sh = ACC_W'(pp) << 64;
      endcase

      y_in     = y_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      frame_in = frame_ff;
      if (start) begin
         y_in     = use_frame ? (dividend >> PRE_FRAME) : (dividend >> PRE_MS);
         acc_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
         frame_in = use_frame;
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      frame_ff <= frame_in;
   end

   assign done     = done_ff;
   assign quotient = frame_ff ? PROD_W'(acc_ff >> SH_FRAME) : PROD_W'(acc_ff >> SH_MS);

endmodule

// ----- sv/swrp_back.sv -----
// ----------------------------------------------------------------------------
// swrp_back
// Executes items: flow table lookup, size computation, ring append/evict.
// ----------------------------------------------------------------------------
module swrp_back import swrp_pkg::*; #(
   parameter int NUM_FLOWS    = DEF_NUM_FLOWS,
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] frame_us,
   input  item_type    q_item,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [31:0] rsp_allowed_sustained,
   output logic [31:0] rsp_allowed_reserved,
   output logic        rsp_flow_known
);

   localparam int FW     = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam int HW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW     = $clog2(WINDOW_DEPTH + 1);
   localparam int RING_N = NUM_FLOWS * WINDOW_DEPTH;
   localparam int AW     = (RING_N > 1) ? $clog2(RING_N) : 1;

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_LOOK   = 13'b0000000000100,
      ST_MUL    = 13'b0000000001000,
      ST_DIVGO  = 13'b0000000010000,
      ST_DIVW   = 13'b0000000100000,
      ST_FIN    = 13'b0000001000000,
      ST_EVRD   = 13'b0000010000000,
      ST_EVDO   = 13'b0000100000000,
      ST_APPEND = 13'b0001000000000,
      ST_AGERD  = 13'b0010000000000,
      ST_AGEDO  = 13'b0100000000000,
      ST_EMIT   = 13'b1000000000000
   } state_type;

   function automatic logic [31:0] cap_size(logic [PROD_W-1:0] v, logic [31:0] burst,
                                            logic [31:0] queue);
      logic [PROD_W-1:0] m;
      m = v;
      if (m > {17'd0, burst}) m = {17'd0, burst};
      if (m > {17'd0, queue}) m = {17'd0, queue};
      return m[31:0];
   endfunction

   // flow table and window ring
   logic             rv_mem [NUM_FLOWS];
   logic [SUM_W-1:0] ss_mem [NUM_FLOWS];
   logic [SUM_W-1:0] sr_mem [NUM_FLOWS];
   logic [HW-1:0]    hd_mem [NUM_FLOWS];
   logic [CW-1:0]    ct_mem [NUM_FLOWS];
   logic [95:0]      ring_mem [RING_N];

   logic             rv_rd_ff;
   logic [SUM_W-1:0] ss_rd_ff, sr_rd_ff;
   logic [HW-1:0]    hd_rd_ff;
   logic [CW-1:0]    ct_rd_ff;
   logic [95:0]      ring_rd_ff;

   state_type        state_ff, state_in;
   logic [FW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   item_type         cur_ff, cur_in;
   logic             known_ff, known_in;
   logic [SUM_W-1:0] sum_s_ff, sum_s_in, sum_r_ff, sum_r_in;
   logic [HW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PROD_W-1:0] prod_s_ff, prod_s_in, prod_r_ff, prod_r_in;
   logic [31:0]      as_ff, as_in, ar_ff, ar_in;
   logic [31:0]      rsp_as_ff, rsp_as_in, rsp_ar_ff, rsp_ar_in;
   logic             rsp_known_ff, rsp_known_in;

   logic              div_start, div_done_s, div_done_r;
   logic [PROD_W-1:0] quo_s, quo_r;
   logic              rec_we, rec_wvalid;
   logic [FW-1:0]     rec_waddr, rec_raddr, fidx;
   logic              ring_we;
   logic [HW-1:0]     ring_wslot, head_inc, tail;
   logic [AW-1:0]     base, ring_waddr, ring_raddr;
   logic [CW:0]       tsum;
   logic [16:0]       op2;
   logic [31:0]       age;
   logic [PROD_W-1:0] q_s, q_r;

   swrp_cdiv u_div_s (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .use_frame (!known_ff),
      .dividend  (prod_s_ff),
      .done      (div_done_s),
      .quotient  (quo_s)
   );

   swrp_cdiv u_div_r (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .use_frame (!known_ff),
      .dividend  (prod_r_ff),
      .done      (div_done_r),
      .quotient  (quo_r)
   );

   always_comb begin
      fidx       = cur_ff.flow_idx[FW-1:0];
      base       = AW'(fidx * WINDOW_DEPTH);
      head_inc   = (head_ff == HW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tsum       = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      tail       = (tsum >= (CW+1)'(WINDOW_DEPTH)) ? HW'(tsum - (CW+1)'(WINDOW_DEPTH))
                                                    : HW'(tsum);
      op2        = known_ff ? {1'b0, cur_ff.window_ms} : frame_us;
      age        = cur_ff.now_us - ring_rd_ff[95:64];
      rec_raddr  = q_item.flow_idx[FW-1:0];
      ring_raddr = base + AW'(head_ff);
      q_s = (quo_s > {9'd0, sum_s_ff}) ? quo_s - {9'd0, sum_s_ff} : '0;
      q_r = (quo_r > {9'd0, sum_r_ff}) ? quo_r - {9'd0, sum_r_ff} : '0;
      if (!known_ff) begin
         q_s = quo_s;
         q_r = quo_r;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cur_in       = cur_ff;
      known_in     = known_ff;
      sum_s_in     = sum_s_ff;
      sum_r_in     = sum_r_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      prod_s_in    = prod_s_ff;
      prod_r_in    = prod_r_ff;
      as_in        = as_ff;
      ar_in        = ar_ff;
      rsp_as_in    = rsp_as_ff;
      rsp_ar_in    = rsp_ar_ff;
      rsp_known_in = rsp_known_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      rec_we       = 1'b0;
      rec_wvalid   = 1'b0;
      rec_waddr    = fidx;
      ring_we      = 1'b0;
      ring_wslot   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            rec_we    = 1'b1;
            rec_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == FW'(NUM_FLOWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            known_in = rv_rd_ff;
            as_in    = '0;
            ar_in    = '0;
            sum_s_in = ss_rd_ff;
            sum_r_in = sr_rd_ff;
            head_in  = hd_rd_ff;
            count_in = ct_rd_ff;
            if (!cur_ff.is_update) begin
               state_in = ST_MUL;
            end else if (!rv_rd_ff) begin
               ring_we    = 1'b1;
               ring_wslot = '0;
               sum_s_in   = SUM_W'(cur_ff.granted_sustained);
               sum_r_in   = SUM_W'(cur_ff.granted_reserved);
               head_in    = '0;
               count_in   = CW'(1);
               state_in   = ST_EMIT;
            end else begin
               state_in = (ct_rd_ff >= CW'(WINDOW_DEPTH)) ? ST_EVRD : ST_APPEND;
            end
         end
         ST_MUL: begin
            prod_s_in = PROD_W'({17'd0, cur_ff.sustained_rate} * {32'd0, op2});
            prod_r_in = PROD_W'({17'd0, cur_ff.reserved_rate} * {32'd0, op2})
                        + (known_ff ? '0 : CEIL_BIAS);
            state_in  = ST_DIVGO;
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done_s && div_done_r) state_in = ST_FIN;
         end
         ST_FIN: begin
            as_in    = cap_size(q_s, cur_ff.max_burst, cur_ff.queue_bytes);
            ar_in    = cap_size(q_r, cur_ff.max_burst, cur_ff.queue_bytes);
            state_in = ST_EMIT;
         end
         ST_EVRD: begin
            state_in = ST_EVDO;
         end
         ST_EVDO: begin
            sum_s_in = sum_s_ff - SUM_W'(ring_rd_ff[63:32]);
            sum_r_in = sum_r_ff - SUM_W'(ring_rd_ff[31:0]);
            head_in  = head_inc;
            count_in = count_ff - 1'b1;
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            ring_we    = 1'b1;
            ring_wslot = tail;
            count_in   = count_ff + 1'b1;
            sum_s_in   = sum_s_ff + SUM_W'(cur_ff.granted_sustained);
            sum_r_in   = sum_r_ff + SUM_W'(cur_ff.granted_reserved);
            state_in   = ST_AGERD;
         end
         ST_AGERD: begin
            state_in = (count_ff == '0) ? ST_EMIT : ST_AGEDO;
         end
         ST_AGEDO: begin
            if (age >= 32'(cur_ff.limit_us)) begin
               sum_s_in = sum_s_ff - SUM_W'(ring_rd_ff[63:32]);
               sum_r_in = sum_r_ff - SUM_W'(ring_rd_ff[31:0]);
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               state_in = ST_AGERD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_as_in    = as_ff;
               rsp_ar_in    = ar_ff;
               rsp_known_in = known_ff;
               rec_we       = cur_ff.is_update;
               rec_wvalid   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      ring_waddr = base + AW'(ring_wslot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      known_ff     <= known_in;
      sum_s_ff     <= sum_s_in;
      sum_r_ff     <= sum_r_in;
      head_ff      <= head_in;
      count_ff     <= count_in;
      prod_s_ff    <= prod_s_in;
      prod_r_ff    <= prod_r_in;
      as_ff        <= as_in;
      ar_ff        <= ar_in;
      rsp_as_ff    <= rsp_as_in;
      rsp_ar_ff    <= rsp_ar_in;
      rsp_known_ff <= rsp_known_in;
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rv_mem[rec_waddr] <= rec_wvalid;
         ss_mem[rec_waddr] <= sum_s_ff;
         sr_mem[rec_waddr] <= sum_r_ff;
         hd_mem[rec_waddr] <= head_ff;
         ct_mem[rec_waddr] <= count_ff;
      end
      rv_rd_ff <= rv_mem[rec_raddr];
      ss_rd_ff <= ss_mem[rec_raddr];
      sr_rd_ff <= sr_mem[rec_raddr];
      hd_rd_ff <= hd_mem[rec_raddr];
      ct_rd_ff <= ct_mem[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= {cur_ff.now_us, cur_ff.granted_sustained,
                                  cur_ff.granted_reserved};
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_allowed_sustained = rsp_as_ff;
   assign rsp_allowed_reserved  = rsp_ar_ff;
   assign rsp_flow_known        = rsp_known_ff;

endmodule

// ----- sim/tb_sliding_window_rate_policer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_policer_unit
// Checks the sliding-window rate policer against an in-bench model of the
// flow table and grant rings: directed corners, then random queries and
// grants over several frame durations and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_policer_unit import swrp_pkg::*; ();

   localparam int LIMIT_CYCLES = 3000000;
   localparam int LIST_DEPTH   = 4096;

   typedef struct {
      logic        op;
      logic [5:0]  flow;
      logic [31:0] now, srate, rrate, burst;
      logic [15:0] win;
      logic [31:0] queue, gsus, gres;
   } policer_item_type;

   typedef struct {
      logic [31:0] asus, ares;
      logic        known;
   } allowance_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [5:0]  req_flow_id = '0;
   logic [31:0] req_now_us = '0;
   logic [31:0] req_sustained_rate = '0;
   logic [31:0] req_reserved_rate = '0;
   logic [31:0] req_max_burst = '0;
   logic [15:0] req_window_ms = '0;
   logic [31:0] req_queue_bytes = '0;
   logic [31:0] req_granted_sustained = '0;
   logic [31:0] req_granted_reserved = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_allowed_sustained;
   logic [31:0] rsp_allowed_reserved;
   logic        rsp_flow_known;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   sliding_window_rate_policer_unit u_top (.*);

   always #5 clock = ~clock;

   // model state
   logic [16:0] frame_us;
   bit          flow_seen [64];
   logic [39:0] sum_sus [64];
   logic [39:0] sum_res [64];
   logic [31:0] ring_stamp [64][16];
   logic [31:0] ring_sus [64][16];
   logic [31:0] ring_res [64][16];
   logic [3:0]  ring_head [64];
   int          ring_cnt [64];

   policer_item_type pend_mem [LIST_DEPTH];
   logic [11:0]      pend_wr = '0;
   logic [11:0]      pend_rd = '0;
   allowance_type    due_mem [LIST_DEPTH];
   logic [11:0]      due_wr = '0;
   logic [11:0]      due_rd = '0;
   policer_item_type on_bus;
   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int cycles = 0;
   logic [31:0] tnow;

   function automatic logic [63:0] window_share(logic [15:0] win, logic [31:0] rate,
                                                logic [39:0] sum);
      logic [63:0] quota;
      quota = (64'(win) * 64'(rate)) / 64'd1000;
      return (quota > 64'(sum)) ? quota - 64'(sum) : 64'd0;
   endfunction

   function automatic logic [31:0] clip(logic [63:0] v, logic [31:0] burst,
                                        logic [31:0] queue);
      if (v > 64'(burst)) v = 64'(burst);
      if (v > 64'(queue)) v = 64'(queue);
      return v[31:0];
   endfunction

   function automatic void drop_oldest(logic [5:0] f);
      sum_sus[f] = sum_sus[f] - 40'(ring_sus[f][ring_head[f]]);
      sum_res[f] = sum_res[f] - 40'(ring_res[f][ring_head[f]]);
      ring_head[f] = ring_head[f] + 4'd1;
      ring_cnt[f]--;
   endfunction

   function automatic allowance_type policer_outcome(policer_item_type it);
      allowance_type r;
      logic [5:0]  f;
      logic [63:0] s, q;
      logic [31:0] lim;
      logic [3:0]  tail;
      f = it.flow;
      r.known = flow_seen[f];
      r.asus = '0;
      r.ares = '0;
      if (it.op == OP_QUERY) begin
         if (!r.known) begin
            q = (64'(it.rrate) * 64'(frame_us) + 64'd7999999) / 64'd8000000;
            s = (64'(it.srate) * 64'(frame_us)) / 64'd8000000;
         end else begin
            s = window_share(it.win, it.srate, sum_sus[f]);
            q = window_share(it.win, it.rrate, sum_res[f]);
         end
         r.asus = clip(s, it.burst, it.queue);
         r.ares = clip(q, it.burst, it.queue);
      end else if (!r.known) begin
         flow_seen[f] = 1'b1;
         ring_head[f] = '0;
         ring_cnt[f] = 1;
         ring_stamp[f][0] = it.now;
         ring_sus[f][0] = it.gsus;
         ring_res[f][0] = it.gres;
         sum_sus[f] = 40'(it.gsus);
         sum_res[f] = 40'(it.gres);
      end else begin
         lim = 32'(it.win) * 32'd1000;
         if (ring_cnt[f] >= 16) drop_oldest(f);
         tail = ring_head[f] + 4'(ring_cnt[f]);
         ring_stamp[f][tail] = it.now;
         ring_sus[f][tail] = it.gsus;
         ring_res[f][tail] = it.gres;
         ring_cnt[f]++;
         sum_sus[f] = sum_sus[f] + 40'(it.gsus);
         sum_res[f] = sum_res[f] + 40'(it.gres);
         while (ring_cnt[f] > 0) begin
            if (it.now - ring_stamp[f][ring_head[f]] < lim) break;
            drop_oldest(f);
         end
      end
      return r;
   endfunction

   task automatic add(logic op, logic [5:0] flow, logic [31:0] now, logic [31:0] sr,
                      logic [31:0] rr, logic [31:0] burst, logic [15:0] win,
                      logic [31:0] queue, logic [31:0] gs, logic [31:0] gr);
      policer_item_type it;
      it = '{op, flow, now, sr, rr, burst, win, queue, gs, gr};
      pend_mem[pend_wr] = it;
      pend_wr = pend_wr + 12'd1;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1000000);
         2: return $urandom_range(0, 100);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic program_frame(logic [16:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      frame_us = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (pend_wr != pend_rd || req_valid || due_wr != due_rd)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_mem[due_wr] = policer_outcome(on_bus);
            due_wr = due_wr + 12'd1;
         end
         if (!req_valid || !req_stall) begin
            if (pend_wr != pend_rd && $urandom_range(0, 99) >= send_idle) begin
               on_bus = pend_mem[pend_rd];
               pend_rd = pend_rd + 12'd1;
               req_valid <= 1'b1;
               req_opcode <= on_bus.op;
               req_flow_id <= on_bus.flow;
               req_now_us <= on_bus.now;
               req_sustained_rate <= on_bus.srate;
               req_reserved_rate <= on_bus.rrate;
               req_max_burst <= on_bus.burst;
               req_window_ms <= on_bus.win;
               req_queue_bytes <= on_bus.queue;
               req_granted_sustained <= on_bus.gsus;
               req_granted_reserved <= on_bus.gres;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      allowance_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_wr == due_rd) begin
               $error("unexpected item: allowed_sustained %h", rsp_allowed_sustained);
               errors++;
            end else begin
               e = due_mem[due_rd];
               due_rd = due_rd + 12'd1;
               if (rsp_allowed_sustained !== e.asus) begin
                  $error("allowed_sustained exp %h got %h", e.asus, rsp_allowed_sustained);
                  errors++;
               end
               if (rsp_allowed_reserved !== e.ares) begin
                  $error("allowed_reserved exp %h got %h", e.ares, rsp_allowed_reserved);
                  errors++;
               end
               if (rsp_flow_known !== e.known) begin
                  $error("flow_known exp %b got %b", e.known, rsp_flow_known);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [16:0] frames [8];
      logic [31:0] t0;
      logic        op;
      logic [5:0]  f;
      logic [15:0] w;
      frame_us = FRAME_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      program_frame(17'd5000);

      // directed corners
      add(OP_QUERY, 6'd63, '1, '1, '1, '1, '1, '1, '1, '1);
      add(OP_QUERY, 6'd0, '0, '0, '0, '0, '0, '0, '0, '0);
      add(OP_QUERY, 6'd62, 0, 1, 1, '1, 5, '1, 0, 0);
      add(OP_QUERY, 6'd61, 0, '1, '1, 32'd7, 5, '1, 0, 0);
      add(OP_QUERY, 6'd61, 0, '1, '1, '1, 5, 32'd9, 0, 0);
      t0 = 32'hFFFF_FF00;
      add(OP_UPDATE, 6'd1, t0, 0, 0, 0, 10, 0, 100, 50);
      add(OP_QUERY, 6'd1, t0, 80000, 80000, '1, 10, '1, 0, 0);
      add(OP_QUERY, 6'd1, t0, 10, 10, '1, 10, '1, 0, 0);
      add(OP_QUERY, 6'd1, t0, '1, '1, 32'd3, 16'hFFFF, '1, 0, 0);
      add(OP_QUERY, 6'd1, t0, '1, '1, '1, 16'hFFFF, 32'd5, 0, 0);
      for (int i = 0; i < 17; i++)
         add(OP_UPDATE, 6'd1, t0 + 32'(i * 40), 0, 0, 0, 10, 0, '1, 32'(i));
      add(OP_QUERY, 6'd1, t0, '1, '1, '1, 16'hFFFF, '1, 0, 0);
      add(OP_UPDATE, 6'd1, t0 + 32'd100000, 0, 0, 0, 10, 0, 7, 7);
      add(OP_UPDATE, 6'd2, 0, 0, 0, 0, 0, 0, 5, 5);
      add(OP_UPDATE, 6'd2, 0, 0, 0, 0, 0, 0, 9, 9);
      add(OP_QUERY, 6'd2, 0, 1000, 1000, '1, 16'hFFFF, '1, 0, 0);
      drain();

      frames = '{17'd1, 17'd100000, 17'd0, 17'd131071, 17'd5000,
                 17'($urandom_range(1, 100000)), 17'($urandom_range(1, 100000)), 17'd1};
      tnow = $urandom;
      for (int ph = 0; ph < 8; ph++) begin
         program_frame(frames[ph]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 81; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 81; end
            default: begin send_idle = 16; recv_idle = 16; end
         endcase
         for (int n = 0; n < 235; n++) begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 4 || op == OP_QUERY && $urandom_range(0, 9) == 0)
               f = 6'($urandom_range(0, 63));
            else
               f = 6'($urandom_range(0, 55));
            if ($urandom_range(0, 49) == 0) tnow = tnow + $urandom;
            else tnow = tnow + $urandom_range(0, 3000);
            w = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 20)) : 16'($urandom);
            add(op, f, tnow, rand_value(), rand_value(),
                ($urandom_range(0, 9) < 7) ? '1 : rand_value(), w,
                ($urandom_range(0, 9) < 7) ? '1 : rand_value(),
                ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 2000)) : $urandom,
                ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 2000)) : $urandom);
         end
         drain();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
